// ----- design/pixel_hit_dedup_and_map_macros.svh -----
// ----------------------------------------------------------------------------
// Pixel hit dedup and map: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_HIT_DEDUP_AND_MAP_MACROS_SVH
`define PIXEL_HIT_DEDUP_AND_MAP_MACROS_SVH

// A condition that holds at every clock edge.
`define PHDM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// An implication checked in the same cycle.
`define PHDM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication checked in the following cycle.
`define PHDM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/phdm_pkg.sv -----
// ----------------------------------------------------------------------------
// Pixel hit dedup and map: package
// Types, register indexes and reset values shared by the block's modules.
// ----------------------------------------------------------------------------
package phdm_pkg;

  localparam int unsigned MAX_HITS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_PW     = $clog2(QUEUE_DEPTH);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [2:0] REG_CHIP_POS_X    = 3'd0;
  localparam logic [2:0] REG_CHIP_POS_Y    = 3'd1;
  localparam logic [2:0] REG_ORIGIN_COLUMN = 3'd2;
  localparam logic [2:0] REG_ORIGIN_LINE   = 3'd3;
  localparam logic [2:0] REG_PITCH_X       = 3'd4;
  localparam logic [2:0] REG_PITCH_Y       = 3'd5;
  localparam logic [2:0] REG_COS_ANGLE     = 3'd6;
  localparam logic [2:0] REG_SIN_ANGLE     = 3'd7;

  localparam logic signed [31:0] RST_CHIP_POS_X    = -32'sd65536;
  localparam logic signed [31:0] RST_CHIP_POS_Y    = -32'sd65536;
  localparam logic        [9:0]  RST_ORIGIN_COLUMN = 10'd512;
  localparam logic        [8:0]  RST_ORIGIN_LINE   = 9'd256;
  localparam logic signed [16:0] RST_PITCH_X       = 17'sd1916;
  localparam logic signed [16:0] RST_PITCH_Y       = 17'sd1762;
  localparam logic signed [17:0] RST_COS_ANGLE     = 18'sd65536;
  localparam logic signed [17:0] RST_SIN_ANGLE     = 18'sd0;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_DUP,
    KIND_FULL,
    KIND_NEW
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  col;
    logic [8:0]  line;
    logic [8:0]  total;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] chip_pos_x;
    logic signed [31:0] chip_pos_y;
    logic        [9:0]  origin_column;
    logic        [8:0]  origin_line;
    logic signed [16:0] pitch_x;
    logic signed [16:0] pitch_y;
    logic signed [17:0] cos_angle;
    logic signed [17:0] sin_angle;
  } cfg_t;

endpackage

// ----- design/phdm_front.sv -----
// ----------------------------------------------------------------------------
// Pixel hit dedup and map: front end
// Accepts items, searches the store for duplicates of add items, classifies
// each item and updates the store and hit count as it queues a command.
// ----------------------------------------------------------------------------
`include "pixel_hit_dedup_and_map_macros.svh"

module phdm_front #(
  parameter int unsigned MAX_HITS = phdm_pkg::MAX_HITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            opcode_i,
  input  logic [9:0]      hit_column_i,
  input  logic [8:0]      hit_line_i,
  output logic            push_o,
  output phdm_pkg::cmd_t  cmd_o,
  input  logic            q_full_i
);

  localparam int unsigned AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned CW = $clog2(MAX_HITS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_PUSH   = 2'd2;

  logic [1:0]           state_q, state_d;
  phdm_pkg::kind_e      kind_q, kind_d;
  logic [9:0]           col_q, col_d;
  logic [8:0]           line_q, line_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic                 rv_q, rv_d;
  logic [18:0]          rdata_q;
  logic [18:0]          mem_q [MAX_HITS];
  logic                 rd_en, wr_en;
  logic [CW+8:0]        total_ext;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    col_d    = col_q;
    line_d   = line_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    rv_d     = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    push_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          col_d    = hit_column_i;
          line_d   = hit_line_i;
          rd_idx_d = '0;
          if (opcode_i == phdm_pkg::OP_CLEAR) begin
            kind_d  = phdm_pkg::KIND_CLEAR;
            state_d = S_PUSH;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (rv_q && (rdata_q == {col_q, line_q})) begin
          kind_d  = phdm_pkg::KIND_DUP;
          state_d = S_PUSH;
        end else if ((rd_idx_q == count_q) && !rv_q) begin
          kind_d  = (count_q == CW'(MAX_HITS)) ? phdm_pkg::KIND_FULL : phdm_pkg::KIND_NEW;
          state_d = S_PUSH;
        end else if (rd_idx_q != count_q) begin
          rd_en    = 1'b1;
          rv_d     = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      S_PUSH: begin
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
          if (kind_q == phdm_pkg::KIND_NEW) begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
          end else if (kind_q == phdm_pkg::KIND_CLEAR) begin
            count_d = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign total_ext   = {9'd0, count_d};
  assign cmd_o.kind  = kind_q;
  assign cmd_o.col   = col_q;
  assign cmd_o.line  = line_q;
  assign cmd_o.total = total_ext[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_idx_q <= '0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    col_q  <= col_d;
    line_q <= line_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= {col_q, line_q};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q[AW-1:0]];
    end
  end

  `PHDM_ASSERT(a_count_bound, count_q <= CW'(MAX_HITS), "hit count exceeds store depth")
  `PHDM_ASSERT_IMP(a_read_in_range, rd_en, (state_q == S_SEARCH) && (rd_idx_q < count_q), "store read beyond hit count")
  `PHDM_ASSERT_IMP(a_append_room, wr_en, count_q < CW'(MAX_HITS), "append to a full store")
  `PHDM_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE, "front idle after accepting an item")

endmodule

// ----- design/phdm_queue.sv -----
// ----------------------------------------------------------------------------
// Pixel hit dedup and map: command queue
// Short first-in first-out queue that decouples the front end from the back.
// ----------------------------------------------------------------------------
module phdm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  phdm_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output phdm_pkg::cmd_t  cmd_o
);

  localparam int unsigned PW = phdm_pkg::QUEUE_PW;
  localparam int unsigned NW = $clog2(phdm_pkg::QUEUE_DEPTH + 1);

  phdm_pkg::cmd_t  entry_q [phdm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [NW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == NW'(phdm_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/phdm_back.sv -----
// ----------------------------------------------------------------------------
// Pixel hit dedup and map: back end
// Maps new hits to rotated chip-plane coordinates in Q16.16 and drives the
// result register, with the duplicate and full flags and the hit total.
// ----------------------------------------------------------------------------
module phdm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  phdm_pkg::cfg_t      cfg_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  phdm_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                duplicate_o,
  output logic                store_full_o,
  output logic signed [31:0]  pos_x_out_o,
  output logic signed [31:0]  pos_y_out_o,
  output logic [8:0]          hit_total_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MAP  = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_SUM  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                out_valid_q;
  logic                load;
  phdm_pkg::cmd_t      cmd_q;
  logic signed [11:0]  dcol, dlin, dx, dy;
  logic signed [28:0]  px, py;
  logic signed [33:0]  x17_q, y17_q;
  logic signed [51:0]  p0_q, p1_q, p2_q, p3_q;
  logic signed [52:0]  rx_q, ry_q;
  logic signed [31:0]  sx, sy;

  function automatic logic signed [31:0] round_sat(input logic signed [52:0] v);
    logic signed [53:0] t;
    logic signed [36:0] r;
    t = 54'(v) + 54'sd65536;
    r = 37'(t >>> 17);
    if (r > 37'sd2147483647) begin
      round_sat = 32'sh7fffffff;
    end else if (r < -37'sd2147483648) begin
      round_sat = 32'sh80000000;
    end else begin
      round_sat = r[31:0];
    end
  endfunction

  assign dcol = $signed({2'b00, cfg_i.origin_column}) - $signed({2'b00, cmd_q.col});
  assign dlin = $signed({3'b000, cfg_i.origin_line}) - $signed({3'b000, cmd_q.line});
  assign dx   = $signed({dcol[10:0], 1'b0}) - 12'sd1;
  assign dy   = $signed({dlin[10:0], 1'b0}) - 12'sd1;
  assign px   = dx * cfg_i.pitch_x;
  assign py   = dy * cfg_i.pitch_y;
  assign sx   = round_sat(rx_q);
  assign sy   = round_sat(ry_q);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_MAP;
        end
      end
      B_MAP: state_d = B_MUL;
      B_MUL: state_d = B_SUM;
      B_SUM: state_d = B_OUT;
      B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == B_MAP) begin
      x17_q <= $signed({cfg_i.chip_pos_x[31], cfg_i.chip_pos_x, 1'b0}) + 34'(px);
      y17_q <= $signed({cfg_i.chip_pos_y[31], cfg_i.chip_pos_y, 1'b0}) + 34'(py);
    end
    if (state_q == B_MUL) begin
      p0_q <= x17_q * cfg_i.cos_angle;
      p1_q <= y17_q * cfg_i.sin_angle;
      p2_q <= x17_q * cfg_i.sin_angle;
      p3_q <= y17_q * cfg_i.cos_angle;
    end
    if (state_q == B_SUM) begin
      rx_q <= 53'(p0_q) - 53'(p1_q);
      ry_q <= 53'(p2_q) + 53'(p3_q);
    end
    if (load) begin
      duplicate_o  <= (cmd_q.kind == phdm_pkg::KIND_DUP);
      store_full_o <= (cmd_q.kind == phdm_pkg::KIND_FULL);
      pos_x_out_o  <= (cmd_q.kind == phdm_pkg::KIND_NEW) ? sx : 32'sd0;
      pos_y_out_o  <= (cmd_q.kind == phdm_pkg::KIND_NEW) ? sy : 32'sd0;
      hit_total_o  <= cmd_q.total;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/pixel_hit_dedup_and_map.sv -----
// ----------------------------------------------------------------------------
// Pixel hit dedup and map: top level
// Per-event pixel hit store with duplicate rejection and mapping of new hits
// to rotated chip-plane coordinates in Q16.16 millimetres.
// ----------------------------------------------------------------------------
// An add item passes through the search and push states of the front end; its
// time there grows with the hit count, which bounds the duplicate search that
// reads the single-port hit store one entry per cycle, and a duplicate ends
// the search early. A clear item skips the search. The back end takes one
// item at a time through its map, multiply, sum and output states and overlaps
// the next search, so items that the front end passes faster, such as clears,
// are held to the back end's pace once the queue has filled. No clearing pass
// is needed after reset: the hit count bounds every search, so the store is
// ready at once.
module pixel_hit_dedup_and_map #(
  parameter int unsigned MAX_HITS = phdm_pkg::MAX_HITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [9:0]         hit_column_i,
  input  logic [8:0]         hit_line_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               duplicate_o,
  output logic               store_full_o,
  output logic signed [31:0] pos_x_out_o,
  output logic signed [31:0] pos_y_out_o,
  output logic [8:0]         hit_total_o
);

  phdm_pkg::cfg_t  cfg_q;
  phdm_pkg::cmd_t  push_cmd, pop_cmd;
  logic            push, q_full, pop, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chip_pos_x    <= phdm_pkg::RST_CHIP_POS_X;
      cfg_q.chip_pos_y    <= phdm_pkg::RST_CHIP_POS_Y;
      cfg_q.origin_column <= phdm_pkg::RST_ORIGIN_COLUMN;
      cfg_q.origin_line   <= phdm_pkg::RST_ORIGIN_LINE;
      cfg_q.pitch_x       <= phdm_pkg::RST_PITCH_X;
      cfg_q.pitch_y       <= phdm_pkg::RST_PITCH_Y;
      cfg_q.cos_angle     <= phdm_pkg::RST_COS_ANGLE;
      cfg_q.sin_angle     <= phdm_pkg::RST_SIN_ANGLE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        phdm_pkg::REG_CHIP_POS_X:    cfg_q.chip_pos_x    <= cfg_data_i;
        phdm_pkg::REG_CHIP_POS_Y:    cfg_q.chip_pos_y    <= cfg_data_i;
        phdm_pkg::REG_ORIGIN_COLUMN: cfg_q.origin_column <= cfg_data_i[9:0];
        phdm_pkg::REG_ORIGIN_LINE:   cfg_q.origin_line   <= cfg_data_i[8:0];
        phdm_pkg::REG_PITCH_X:       cfg_q.pitch_x       <= cfg_data_i[16:0];
        phdm_pkg::REG_PITCH_Y:       cfg_q.pitch_y       <= cfg_data_i[16:0];
        phdm_pkg::REG_COS_ANGLE:     cfg_q.cos_angle     <= cfg_data_i[17:0];
        phdm_pkg::REG_SIN_ANGLE:     cfg_q.sin_angle     <= cfg_data_i[17:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  phdm_front #(
    .MAX_HITS (MAX_HITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .hit_column_i (hit_column_i),
    .hit_line_i   (hit_line_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .q_full_i     (q_full)
  );

  phdm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (pop_cmd)
  );

  phdm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .cmd_i        (pop_cmd),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .duplicate_o  (duplicate_o),
    .store_full_o (store_full_o),
    .pos_x_out_o  (pos_x_out_o),
    .pos_y_out_o  (pos_y_out_o),
    .hit_total_o  (hit_total_o)
  );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Pixel hit dedup and map: testbench
// Sends pixel hit and clear items to the block, with random gaps on the send
// side and random stalls on the result side. A model of the hit store and the
// coordinate mapping, held in this file, works out each expected result that
// a typed row does not give. The block's results are compared field by field
// in the order of acceptance. The run starts with a short table of directed
// items under the reset settings. It then goes through four register settings:
// two sets of extremes, one of plausible geometry and one fully random. Each
// setting gets random events; one event fills the store past its limit.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned STORE_DEPTH = phdm_pkg::MAX_HITS_DEF;

  typedef struct packed {
    logic               dup;
    logic               full;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [8:0]         total;
  } hit_result_t;

  typedef struct packed {
    logic        op;
    logic [9:0]  col;
    logic [8:0]  line;
    logic        typed;
    hit_result_t want;
  } probe_row_t;

  localparam hit_result_t NO_TYPED = '0;

  // Directed items under the reset settings; typed rows carry their result.
  localparam probe_row_t PROBES [17] = '{
    '{phdm_pkg::OP_CLEAR, 10'd0,    9'd0,   1'b1, '{1'b0, 1'b0, 32'sd0, 32'sd0, 9'd0}},
    '{phdm_pkg::OP_ADD,   10'd512,  9'd256, 1'b1,
      '{1'b0, 1'b0, -32'sd66494, -32'sd66417, 9'd1}},
    '{phdm_pkg::OP_ADD,   10'd512,  9'd256, 1'b1, '{1'b1, 1'b0, 32'sd0, 32'sd0, 9'd1}},
    '{phdm_pkg::OP_ADD,   10'd0,    9'd0,   1'b0, NO_TYPED},
    '{phdm_pkg::OP_ADD,   10'd1023, 9'd511, 1'b0, NO_TYPED},
    '{phdm_pkg::OP_ADD,   10'd1023, 9'd0,   1'b0, NO_TYPED},
    '{phdm_pkg::OP_ADD,   10'd0,    9'd511, 1'b0, NO_TYPED},
    '{phdm_pkg::OP_ADD,   10'd0,    9'd0,   1'b1, '{1'b1, 1'b0, 32'sd0, 32'sd0, 9'd5}},
    '{phdm_pkg::OP_ADD,   10'd1023, 9'd511, 1'b1, '{1'b1, 1'b0, 32'sd0, 32'sd0, 9'd5}},
    '{phdm_pkg::OP_ADD,   10'd512,  9'd255, 1'b0, NO_TYPED},
    '{phdm_pkg::OP_ADD,   10'd511,  9'd256, 1'b0, NO_TYPED},
    '{phdm_pkg::OP_ADD,   10'd341,  9'd170, 1'b0, NO_TYPED},
    '{phdm_pkg::OP_ADD,   10'd682,  9'd341, 1'b0, NO_TYPED},
    '{phdm_pkg::OP_CLEAR, 10'd1023, 9'd511, 1'b1, '{1'b0, 1'b0, 32'sd0, 32'sd0, 9'd0}},
    '{phdm_pkg::OP_ADD,   10'd0,    9'd0,   1'b0, NO_TYPED},
    '{phdm_pkg::OP_CLEAR, 10'd0,    9'd0,   1'b1, '{1'b0, 1'b0, 32'sd0, 32'sd0, 9'd0}},
    '{phdm_pkg::OP_CLEAR, 10'd0,    9'd0,   1'b1, '{1'b0, 1'b0, 32'sd0, 32'sd0, 9'd0}}
  };

  localparam int PHASE_ITEMS [4] = '{60, 60, 350, 130};

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [2:0]         cfg_idx_i    = phdm_pkg::REG_CHIP_POS_X;
  logic [31:0]        cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               opcode_i     = phdm_pkg::OP_ADD;
  logic [9:0]         hit_column_i = '0;
  logic [8:0]         hit_line_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               duplicate_o;
  logic               store_full_o;
  logic signed [31:0] pos_x_out_o;
  logic signed [31:0] pos_y_out_o;
  logic [8:0]         hit_total_o;

  // Model state: register copies and the hit store.
  logic signed [31:0] m_pos_x      = phdm_pkg::RST_CHIP_POS_X;
  logic signed [31:0] m_pos_y      = phdm_pkg::RST_CHIP_POS_Y;
  logic        [9:0]  m_org_col    = phdm_pkg::RST_ORIGIN_COLUMN;
  logic        [8:0]  m_org_line   = phdm_pkg::RST_ORIGIN_LINE;
  logic signed [16:0] m_pitch_x    = phdm_pkg::RST_PITCH_X;
  logic signed [16:0] m_pitch_y    = phdm_pkg::RST_PITCH_Y;
  logic signed [17:0] m_cos        = phdm_pkg::RST_COS_ANGLE;
  logic signed [17:0] m_sin        = phdm_pkg::RST_SIN_ANGLE;
  logic [18:0]        hit_keys [STORE_DEPTH];
  int unsigned        hits_stored  = 0;

  hit_result_t        pending_results [$];
  hit_result_t        oldest;
  int unsigned        mismatch_count = 0;
  int unsigned        items_sent     = 0;
  bit                 tx_burst       = 1'b0;
  bit                 pause_due      = 1'b1;
  int                 rx_hold        = 0;
  int                 rx_roll        = 0;
  int                 rx_cycles      = 0;
  bit                 rx_quiet       = 1'b0;

  pixel_hit_dedup_and_map dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .hit_column_i,
    .hit_line_i,
    .out_valid_o,
    .out_stall_i,
    .duplicate_o,
    .store_full_o,
    .pos_x_out_o,
    .pos_y_out_o,
    .hit_total_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [31:0] round_q16(input longint signed q33);
    longint signed r;
    r = (q33 + 64'sd65536) >>> 17;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic hit_result_t predict_hit(input logic op, input logic [9:0] col,
                                              input logic [8:0] line);
    hit_result_t   res;
    logic [18:0]   key;
    longint signed x17;
    longint signed y17;
    res = '0;
    key = {col, line};
    if (op == phdm_pkg::OP_CLEAR) begin
      hits_stored = 0;
      return res;
    end
    for (int i = 0; i < hits_stored; i++) begin
      if (hit_keys[i] == key) begin
        res.dup   = 1'b1;
        res.total = 9'(hits_stored);
        return res;
      end
    end
    if (hits_stored >= STORE_DEPTH) begin
      res.full  = 1'b1;
      res.total = 9'(hits_stored);
      return res;
    end
    x17 = 2 * longint'(m_pos_x)
        + (2 * (longint'(m_org_col) - longint'(col)) - 1) * longint'(m_pitch_x);
    y17 = 2 * longint'(m_pos_y)
        + (2 * (longint'(m_org_line) - longint'(line)) - 1) * longint'(m_pitch_y);
    res.px = round_q16(x17 * longint'(m_cos) - y17 * longint'(m_sin));
    res.py = round_q16(x17 * longint'(m_sin) + y17 * longint'(m_cos));
    hit_keys[hits_stored] = key;
    hits_stored++;
    res.total = 9'(hits_stored);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected, hit_total", hit_total_o, 0);
      end else begin
        oldest = pending_results.pop_front();
        if (duplicate_o !== oldest.dup) report_mismatch("duplicate", duplicate_o, oldest.dup);
        if (store_full_o !== oldest.full) begin
          report_mismatch("store_full", store_full_o, oldest.full);
        end
        if (pos_x_out_o !== oldest.px) report_mismatch("pos_x_out", pos_x_out_o, oldest.px);
        if (pos_y_out_o !== oldest.py) report_mismatch("pos_y_out", pos_y_out_o, oldest.py);
        if (hit_total_o !== oldest.total) begin
          report_mismatch("hit_total", hit_total_o, oldest.total);
        end
      end
    end
  end

  // Result side: mostly short stalls, a few long ones, and quiet stretches.
  always @(negedge clk_i) begin
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles % 256 == 0) rx_quiet <= ($urandom_range(0, 3) == 0);
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold     <= rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_quiet || rx_roll < 60) begin
        out_stall_i <= 1'b0;
      end else if (rx_roll < 93) begin
        out_stall_i <= 1'b1;
        rx_hold     <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        rx_hold     <= $urandom_range(5, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic drive_hit(input logic op, input logic [9:0] col, input logic [8:0] line,
                           input logic typed, input hit_result_t given);
    int          gap;
    hit_result_t pred;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    hit_column_i <= col;
    hit_line_i   <= line;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_hit(op, col, line);
    pending_results.push_back(typed ? given : pred);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      phdm_pkg::REG_CHIP_POS_X:    m_pos_x    = data;
      phdm_pkg::REG_CHIP_POS_Y:    m_pos_y    = data;
      phdm_pkg::REG_ORIGIN_COLUMN: m_org_col  = data[9:0];
      phdm_pkg::REG_ORIGIN_LINE:   m_org_line = data[8:0];
      phdm_pkg::REG_PITCH_X:       m_pitch_x  = data[16:0];
      phdm_pkg::REG_PITCH_Y:       m_pitch_y  = data[16:0];
      phdm_pkg::REG_COS_ANGLE:     m_cos      = data[17:0];
      phdm_pkg::REG_SIN_ANGLE:     m_sin      = data[17:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_geometry(input logic [31:0] pos_x, input logic [31:0] pos_y,
                               input logic [31:0] org_c, input logic [31:0] org_l,
                               input logic [31:0] pit_x, input logic [31:0] pit_y,
                               input logic [31:0] cs, input logic [31:0] sn);
    write_reg(phdm_pkg::REG_CHIP_POS_X, pos_x);
    write_reg(phdm_pkg::REG_CHIP_POS_Y, pos_y);
    write_reg(phdm_pkg::REG_ORIGIN_COLUMN, org_c);
    write_reg(phdm_pkg::REG_ORIGIN_LINE, org_l);
    write_reg(phdm_pkg::REG_PITCH_X, pit_x);
    write_reg(phdm_pkg::REG_PITCH_Y, pit_y);
    write_reg(phdm_pkg::REG_COS_ANGLE, cs);
    write_reg(phdm_pkg::REG_SIN_ANGLE, sn);
  endtask

  // An event is usually a clear followed by hits; some repeat stored hits, a
  // few are corner pixels, and a little noise breaks the pattern.
  task automatic run_event(input int adds, input int noise_pct, input int dup_pct,
                           input int ext_pct);
    int          r;
    logic [18:0] k;
    tx_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) != 0) begin
      drive_hit(phdm_pkg::OP_CLEAR, 10'($urandom_range(0, 1023)),
                9'($urandom_range(0, 511)), 1'b0, NO_TYPED);
    end
    for (int i = 0; i < adds; i++) begin
      r = $urandom_range(0, 99);
      if (r < noise_pct) begin
        drive_hit(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                  9'($urandom_range(0, 511)), 1'b0, NO_TYPED);
      end else if (r < noise_pct + dup_pct && hits_stored > 0) begin
        k = hit_keys[$urandom_range(0, hits_stored - 1)];
        drive_hit(phdm_pkg::OP_ADD, k[18:9], k[8:0], 1'b0, NO_TYPED);
      end else if (r < noise_pct + dup_pct + ext_pct) begin
        drive_hit(phdm_pkg::OP_ADD, $urandom_range(0, 1) ? 10'd1023 : 10'd0,
                  $urandom_range(0, 1) ? 9'd511 : 9'd0, 1'b0, NO_TYPED);
      end else begin
        drive_hit(phdm_pkg::OP_ADD, 10'($urandom_range(0, 1023)),
                  9'($urandom_range(0, 511)), 1'b0, NO_TYPED);
      end
      if (pause_due && adds > 8 && i == adds / 2) begin
        wait_for_results();
        pause_due = 1'b0;
      end
    end
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (PROBES[i]) begin
      drive_hit(PROBES[i].op, PROBES[i].col, PROBES[i].line, PROBES[i].typed,
                PROBES[i].want);
    end

    for (int p = 0; p < 4; p++) begin
      wait_for_results();
      case (p)
        0: load_geometry(32'h7FFF_FFFF, 32'h8000_0000, 1023, 0, 65535, -65536,
                         65536, -65536);
        1: load_geometry(32'h8000_0000, 32'h7FFF_FFFF, 0, 511, -65536, 65535,
                         -65536, 65536);
        2: load_geometry($urandom_range(0, 40 * 65536) - 20 * 65536,
                         $urandom_range(0, 40 * 65536) - 20 * 65536,
                         $urandom_range(0, 1023), $urandom_range(0, 511),
                         $urandom_range(0, 1) ? $urandom_range(1000, 3000)
                                              : -$urandom_range(1000, 3000),
                         $urandom_range(0, 1) ? $urandom_range(1000, 3000)
                                              : -$urandom_range(1000, 3000),
                         $urandom_range(0, 131072) - 65536,
                         $urandom_range(0, 131072) - 65536);
        default: load_geometry($urandom(), $urandom(), $urandom_range(0, 1023),
                               $urandom_range(0, 511), $urandom_range(0, 131071) - 65536,
                               $urandom_range(0, 131071) - 65536,
                               $urandom_range(0, 131072) - 65536,
                               $urandom_range(0, 131072) - 65536);
      endcase
      target = items_sent + PHASE_ITEMS[p];
      if (p == 2) run_event(330, 0, 5, 3);
      while (items_sent < target) begin
        run_event(($urandom_range(0, 99) < 70) ? $urandom_range(1, 12)
                                               : $urandom_range(13, 60), 4, 25, 10);
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
